// ===== rtl/cphd_pkg.sv =====
// Shared types, register indexes and saturation helper for the column peak hold decimator.
`timescale 1ns / 1ps

package cphd_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MODE      = 3'd0,
        CFG_X_GAIN    = 3'd1,
        CFG_X_BIAS    = 3'd2,
        CFG_Y_GAIN    = 3'd3,
        CFG_Y_BIAS    = 3'd4,
        CFG_LINE_HALF = 3'd5
    } t_cfg_index;

    localparam int CFG_INDEX_W = 3;

    // Output queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // One mapped point on its way to the column stage.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               first_point;
        logic               last_point;
    } t_point;

    // One result item.
    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [31:0] band_top;
        logic signed [31:0] band_bottom;
        logic               end_of_run;
    } t_result;

    // Results written to the output queue in one cycle, first in r0.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        begin
            if (v[32] != v[31]) begin
                r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/column_peak_hold_decimator.sv =====
// Top level of the column peak hold decimator: configuration registers, pipeline and queue.
`timescale 1ns / 1ps

// Usage:
// Profile points enter on the s_axis channel, one item per cycle when s_axis_tready is
// high; tuser flags the first point of a run and tlast its last point. Results leave on
// m_axis, tlast marking the closing result of a run. Registers are written through the
// cfg channel (index, data); the user writes them only while the block is idle, which the
// block itself does not enforce; o_cfg_ready is always high.
// The datapath is three register stages: multiply, scale and clamp, column compare.
// Throughput is one item per cycle while items give at most one result each and the
// receiver is ready; two results leave singly. The output queue holds four results, and
// s_axis_tready drops whenever fewer than two entries are free, so a stalled receiver
// stops input after at most a few items without losing any. s_axis_tready depends only
// on registered queue state, not on m_axis_tready.
// Reset (synchronous, active low) empties the pipeline and queue, clears the held column
// point and the run start, and loads the register defaults: mode 0, both gains 1.0,
// both biases 0 and half line width 0.5 pixel.

module column_peak_hold_decimator #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [55:0]                       s_axis_tdata,  // distance[31:0], elevation[55:32]
    input  logic                              s_axis_tuser,  // first_point
    input  logic                              s_axis_tlast,  // last_point
    // Result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [127:0]                      m_axis_tdata,  // x_pos, y_pos, band_top,
                                                             // band_bottom, 32 bits each
    output logic                              m_axis_tlast,  // end_of_run
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cphd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic                r_mode;
    logic [31:0]         r_x_gain;
    logic signed [31:0]  r_x_bias;
    logic [31:0]         r_y_gain;
    logic signed [31:0]  r_y_bias;
    logic [15:0]         r_line_half;

    logic                w_adv;
    logic                w_v1;
    logic                w_v2;
    logic                w_fire;
    cphd_pkg::t_point    w_point;
    cphd_pkg::t_push     w_push;
    cphd_pkg::t_result   w_out;
    logic                w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_x_gain    <= 32'd65536;
            r_x_bias    <= '0;
            r_y_gain    <= 32'd65536;
            r_y_bias    <= '0;
            r_line_half <= 16'd128;
        end else if (i_cfg_valid) begin
            case (cphd_pkg::t_cfg_index'(i_cfg_index))
                cphd_pkg::CFG_MODE:      r_mode      <= i_cfg_data[0];
                cphd_pkg::CFG_X_GAIN:    r_x_gain    <= i_cfg_data;
                cphd_pkg::CFG_X_BIAS:    r_x_bias    <= i_cfg_data;
                cphd_pkg::CFG_Y_GAIN:    r_y_gain    <= i_cfg_data;
                cphd_pkg::CFG_Y_BIAS:    r_y_bias    <= i_cfg_data;
                cphd_pkg::CFG_LINE_HALF: r_line_half <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The whole pipeline moves together whenever the queue can take two results.
    assign w_adv         = w_room;
    assign s_axis_tready = w_adv;
    assign w_fire        = w_v2 && w_adv;

    cphd_map #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_valid        (s_axis_tvalid),
        .i_distance     (s_axis_tdata[31:0]),
        .i_elevation    (s_axis_tdata[55:32]),
        .i_first_point  (s_axis_tuser),
        .i_last_point   (s_axis_tlast),
        .i_x_gain       (r_x_gain),
        .i_x_bias       (r_x_bias),
        .i_y_gain       (r_y_gain),
        .i_y_bias       (r_y_bias),
        .o_stage1_valid (w_v1),
        .o_valid        (w_v2),
        .o_point        (w_point)
    );

    cphd_column #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_column (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_point     (w_point),
        .i_mode      (r_mode),
        .i_line_half (r_line_half),
        .o_push      (w_push)
    );

    cphd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (m_axis_tvalid && m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .o_room  (w_room)
    );

    assign m_axis_tdata = {w_out.band_bottom, w_out.band_top, w_out.y_pos, w_out.x_pos};
    assign m_axis_tlast = w_out.end_of_run;

    // Input stalls only while results are backed up in the queue.
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with an empty result queue");

    // An accepted item always reaches the first pipeline stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_v1)
        else $error("accepted item lost before the first stage");

    // Results written to the queue are offered on the next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |=> m_axis_tvalid)
        else $error("queued result not presented");

    // Results are only produced by an item leaving the compare stage.
    a_push_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> w_fire)
        else $error("result produced without an item");

endmodule

// ===== rtl/cphd_map.sv =====
// Two-stage affine mapping of profile points to saturated Q24.8 screen coordinates.
`timescale 1ns / 1ps

module cphd_map #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_distance,
    input  logic signed [23:0]    i_elevation,
    input  logic                  i_first_point,
    input  logic                  i_last_point,
    input  logic [31:0]           i_x_gain,
    input  logic signed [31:0]    i_x_bias,
    input  logic [31:0]           i_y_gain,
    input  logic signed [31:0]    i_y_bias,
    output logic                  o_stage1_valid,
    output logic                  o_valid,
    output cphd_pkg::t_point      o_point
);

    logic                  r_v1;
    logic                  r_v2;
    logic [63:0]           r_prod_x;
    logic signed [56:0]    r_prod_y;
    logic                  r_first;
    logic                  r_last;
    cphd_pkg::t_point      r_point;

    logic [63:0]           w_prod_x;
    logic signed [56:0]    w_prod_y;
    logic [63:0]           w_xs;
    logic signed [65:0]    w_x_sum;
    logic signed [56:0]    w_ys;
    logic signed [57:0]    w_y_diff;
    logic signed [31:0]    w_x;
    logic signed [31:0]    w_y;

    assign w_prod_x = i_distance * i_x_gain;
    assign w_prod_y = i_elevation * signed'({1'b0, i_y_gain});

    // Second stage: scale down, add the offset and clamp to 32 bits.
    always_comb begin
        w_xs     = r_prod_x >> GAIN_FRAC_BITS;
        w_x_sum  = signed'({2'b00, w_xs}) + 66'(i_x_bias);
        w_ys     = r_prod_y >>> GAIN_FRAC_BITS;
        w_y_diff = 58'(i_y_bias) - 58'(w_ys);

        if ((&w_x_sum[65:31]) || !(|w_x_sum[65:31])) begin
            w_x = w_x_sum[31:0];
        end else begin
            w_x = w_x_sum[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end

        if ((&w_y_diff[57:31]) || !(|w_y_diff[57:31])) begin
            w_y = w_y_diff[31:0];
        end else begin
            w_y = w_y_diff[57] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x            <= w_prod_x;
            r_prod_y            <= w_prod_y;
            r_first             <= i_first_point;
            r_last              <= i_last_point;
            r_point.x           <= w_x;
            r_point.y           <= w_y;
            r_point.first_point <= r_first;
            r_point.last_point  <= r_last;
        end
    end

    assign o_stage1_valid = r_v1;
    assign o_valid        = r_v2;
    assign o_point        = r_point;

endmodule

// ===== rtl/cphd_column.sv =====
// Column bucketing: holds the extreme point of the current pixel column and builds results.
`timescale 1ns / 1ps

module cphd_column #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  cphd_pkg::t_point    i_point,
    input  logic                i_mode,
    input  logic [15:0]         i_line_half,
    output cphd_pkg::t_push     o_push
);

    localparam logic [15:0]        MIN_HALF = 16'((3 << COORD_FRAC_BITS) >> 2);
    localparam logic signed [32:0] ONE_PX   = 33'(1 << COORD_FRAC_BITS);

    logic [23:0]         r_column;
    logic signed [31:0]  r_held_x;
    logic signed [31:0]  r_held_y;
    logic                r_held_valid;
    logic signed [31:0]  r_start_x;

    logic [23:0]         n_column;
    logic signed [31:0]  n_held_x;
    logic signed [31:0]  n_held_y;
    logic                n_held_valid;
    logic signed [31:0]  n_start_x;

    logic [15:0]         w_half;
    logic [23:0]         w_bx;
    logic                w_bk_emit;
    logic                w_bk_take;
    logic signed [32:0]  w_min_x;
    logic signed [31:0]  w_last_x;
    cphd_pkg::t_result   w_tail;
    cphd_pkg::t_push     w_push;

    // Column number is the floor of x in pixels, wrapped to 24 bits.
    function automatic logic [23:0] col_of(input logic signed [31:0] x);
        logic signed [55:0] xe;
        begin
            xe = 56'(x);
            return xe[COORD_FRAC_BITS +: 24];
        end
    endfunction

    function automatic cphd_pkg::t_result make_result(
        input logic signed [31:0] x,
        input logic signed [31:0] y,
        input logic               eor,
        input logic [15:0]        half
    );
        cphd_pkg::t_result r;
        begin
            r.x_pos       = x;
            r.y_pos       = y;
            r.band_top    = cphd_pkg::sat33(33'(y) - signed'({17'b0, half}));
            r.band_bottom = cphd_pkg::sat33(33'(y) + signed'({17'b0, half}));
            r.end_of_run  = eor;
            return r;
        end
    endfunction

    always_comb begin
        w_half    = i_mode ? MIN_HALF : i_line_half;
        w_bx      = col_of(i_point.x);
        // A new column flushes the held point; inside a column the better point wins.
        w_bk_emit = r_held_valid && (w_bx != r_column);
        w_bk_take = !r_held_valid || (w_bx != r_column) ||
                    (i_mode ? (i_point.y > r_held_y) : (i_point.y < r_held_y));

        n_column     = r_column;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_held_valid = r_held_valid;
        n_start_x    = r_start_x;
        w_push       = '0;
        w_min_x      = '0;
        w_last_x     = i_point.x;
        w_tail       = '0;

        if (!i_mode) begin
            if (i_point.first_point) begin
                w_push.r0    = make_result(i_point.x, i_point.y, 1'b0, w_half);
                w_push.cnt   = 2'd1;
                n_start_x    = i_point.x;
                n_column     = w_bx;
                n_held_valid = 1'b0;
            end else if (!i_point.last_point) begin
                if (w_bk_emit) begin
                    w_push.r0  = make_result(r_held_x, r_held_y, 1'b0, w_half);
                    w_push.cnt = 2'd1;
                end
                if (w_bk_take) begin
                    n_column     = w_bx;
                    n_held_x     = i_point.x;
                    n_held_y     = i_point.y;
                    n_held_valid = 1'b1;
                end
            end
            if (i_point.last_point) begin
                // The closing point lies at least one pixel right of the run start.
                w_min_x  = 33'(n_start_x) + ONE_PX;
                w_last_x = (33'(i_point.x) < w_min_x) ? cphd_pkg::sat33(w_min_x)
                                                      : i_point.x;
                if (!i_point.first_point && r_held_valid) begin
                    w_push.r0  = make_result(r_held_x, r_held_y, 1'b0, w_half);
                    w_push.cnt = 2'd1;
                end
                w_tail       = make_result(w_last_x, i_point.y, 1'b1, w_half);
                n_held_valid = 1'b0;
            end
        end else begin
            if (i_point.first_point) begin
                n_column     = w_bx;
                n_held_x     = i_point.x;
                n_held_y     = i_point.y;
                n_held_valid = 1'b1;
            end else begin
                if (w_bk_emit) begin
                    w_push.r0  = make_result(r_held_x, r_held_y, 1'b0, w_half);
                    w_push.cnt = 2'd1;
                end
                if (w_bk_take) begin
                    n_column     = w_bx;
                    n_held_x     = i_point.x;
                    n_held_y     = i_point.y;
                    n_held_valid = 1'b1;
                end
            end
            if (i_point.last_point) begin
                w_tail       = make_result(n_held_x, n_held_y, 1'b1, w_half);
                n_held_valid = 1'b0;
            end
        end

        if (i_point.last_point) begin
            if (w_push.cnt == 2'd0) begin
                w_push.r0 = w_tail;
            end else begin
                w_push.r1 = w_tail;
            end
            w_push.cnt = w_push.cnt + 2'd1;
        end

        if (!i_fire) begin
            w_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_valid <= 1'b0;
            r_start_x    <= '0;
        end else if (i_fire) begin
            r_column     <= n_column;
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
            r_held_valid <= n_held_valid;
            r_start_x    <= n_start_x;
        end
    end

    assign o_push = w_push;

endmodule

// ===== rtl/cphd_fifo.sv =====
// Four-entry result queue that takes up to two items per cycle and gives one.
`timescale 1ns / 1ps

module cphd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cphd_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_valid,
    output cphd_pkg::t_result   o_data,
    output logic                o_room
);

    cphd_pkg::t_result                     r_mem [cphd_pkg::FIFO_DEPTH];
    logic [cphd_pkg::FIFO_PTR_W-1:0]       r_wr;
    logic [cphd_pkg::FIFO_PTR_W-1:0]       r_rd;
    logic [cphd_pkg::FIFO_CNT_W-1:0]       r_count;
    logic [cphd_pkg::FIFO_PTR_W-1:0]       w_wr1;

    assign w_wr1 = r_wr + cphd_pkg::FIFO_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + cphd_pkg::FIFO_PTR_W'(i_push.cnt);
            r_rd    <= r_rd + cphd_pkg::FIFO_PTR_W'(i_pop);
            r_count <= r_count + cphd_pkg::FIFO_CNT_W'(i_push.cnt)
                               - cphd_pkg::FIFO_CNT_W'(i_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    // Room for the worst case of two items from one input item.
    assign o_room  = (r_count <= cphd_pkg::FIFO_CNT_W'(cphd_pkg::FIFO_DEPTH - 2));

endmodule
